// File: rtl/ifd_pkg.sv
// ----------------------------------------------------------------------------
// IMU frame decoder package
// Shared types and constants for the IMU frame decoder.
// ----------------------------------------------------------------------------
package ifd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned POS_W    = 4;
    localparam int unsigned PAY_N    = 8;
    localparam int unsigned PAY_IDX_W = 3;
    localparam int unsigned ADDR_W   = 4;
    localparam int unsigned DATA_W   = 32;

    // Position of the check byte within an 11-byte window.
    localparam logic [POS_W-1:0] LAST_POS  = 4'd10;
    localparam logic [POS_W-1:0] POS_FIRST = 4'd0;
    localparam logic [POS_W-1:0] POS_KIND  = 4'd1;
    localparam logic [POS_W-1:0] POS_PAY0  = 4'd2;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h55;
    localparam logic [BYTE_W-1:0] RATE_RESET   = 8'h52;
    localparam logic [BYTE_W-1:0] ANGLE_RESET  = 8'h53;
    localparam logic [BYTE_W-1:0] QUAT_RESET   = 8'h59;

    typedef enum logic [2:0] {
        ST_RATE    = 3'd0,
        ST_ANGLE   = 3'd1,
        ST_QUAT    = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_BAD_HDR = 3'd4,
        ST_BAD_SUM = 3'd5
    } frame_status_t;

    typedef enum logic [1:0] {
        REG_HEADER = 2'd0,
        REG_RATE   = 2'd1,
        REG_ANGLE  = 2'd2,
        REG_QUAT   = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [BYTE_W-1:0] header_value;
        logic [BYTE_W-1:0] rate_type_code;
        logic [BYTE_W-1:0] angle_type_code;
        logic [BYTE_W-1:0] quat_type_code;
    } cfg_t;

    typedef struct packed {
        frame_status_t      frame_status;
        logic [WORD_W-1:0]  word_x;
        logic [WORD_W-1:0]  word_y;
        logic [WORD_W-1:0]  word_z;
        logic [WORD_W-1:0]  word_w;
    } result_t;

    typedef struct packed {
        logic at_check;
        logic accept;
    } frame_ctl_t;

endpackage

// File: rtl/ifd_stream_if.sv
// ----------------------------------------------------------------------------
// IMU frame decoder stream interfaces
// Valid/ready channels for received bytes and for decoded frames.
// ----------------------------------------------------------------------------
interface ifd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ifd_result_if;
    logic               valid;
    logic               ready;
    logic [2:0]         frame_status;
    logic signed [15:0] word_x;
    logic signed [15:0] word_y;
    logic signed [15:0] word_z;
    logic signed [15:0] word_w;

    modport source (output valid, output frame_status, output word_x, output word_y,
                    output word_z, output word_w, input ready);
    modport sink   (input valid, input frame_status, input word_x, input word_y,
                    input word_z, input word_w, output ready);
endinterface

// File: rtl/ifd_cfg_regs.sv
// ----------------------------------------------------------------------------
// IMU frame decoder configuration registers
// APB-style register file holding the header and the three type codes.
// ----------------------------------------------------------------------------
module ifd_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ifd_pkg::ADDR_W-1:0]    paddr,
    input  logic [ifd_pkg::DATA_W-1:0]    pwdata,
    output logic [ifd_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output ifd_pkg::cfg_t                 cfg
);

    ifd_pkg::cfg_t      cfg_reg;
    ifd_pkg::cfg_t      cfg_next;
    ifd_pkg::reg_index_t idx;
    logic               wr_en;
    logic [7:0]         wbyte;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = ifd_pkg::reg_index_t'(paddr[3:2]);
    assign wbyte  = pwdata[7:0];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                ifd_pkg::REG_HEADER: cfg_next.header_value    = wbyte;
                ifd_pkg::REG_RATE:   cfg_next.rate_type_code  = wbyte;
                ifd_pkg::REG_ANGLE:  cfg_next.angle_type_code = wbyte;
                ifd_pkg::REG_QUAT:   cfg_next.quat_type_code  = wbyte;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            ifd_pkg::REG_HEADER: prdata = {24'd0, cfg_reg.header_value};
            ifd_pkg::REG_RATE:   prdata = {24'd0, cfg_reg.rate_type_code};
            ifd_pkg::REG_ANGLE:  prdata = {24'd0, cfg_reg.angle_type_code};
            ifd_pkg::REG_QUAT:   prdata = {24'd0, cfg_reg.quat_type_code};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_value    <= ifd_pkg::HEADER_RESET;
            cfg_reg.rate_type_code  <= ifd_pkg::RATE_RESET;
            cfg_reg.angle_type_code <= ifd_pkg::ANGLE_RESET;
            cfg_reg.quat_type_code  <= ifd_pkg::QUAT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/ifd_frame_unit.sv
// ----------------------------------------------------------------------------
// IMU frame decoder window unit
// Counts bytes in the 11-byte window, keeps the running sum, captures the
// frame bytes and classifies the frame when the check byte arrives.
// ----------------------------------------------------------------------------
module ifd_frame_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [ifd_pkg::BYTE_W-1:0]  rx_byte,
    input  ifd_pkg::cfg_t               cfg,
    output ifd_pkg::frame_ctl_t         ctl,
    output ifd_pkg::result_t            result
);

    logic [ifd_pkg::POS_W-1:0]  pos_reg,   pos_next;
    logic [ifd_pkg::BYTE_W-1:0] sum_reg,   sum_next;
    logic [ifd_pkg::BYTE_W-1:0] first_reg, first_next;
    logic [ifd_pkg::BYTE_W-1:0] kind_reg,  kind_next;
    logic [ifd_pkg::BYTE_W-1:0] pay_reg [ifd_pkg::PAY_N];

    logic                          at_check;
    logic [ifd_pkg::POS_W-1:0]     pay_off;
    logic [ifd_pkg::PAY_IDX_W-1:0] pay_idx;
    logic                          pay_wr;
    ifd_pkg::frame_status_t        status;
    logic                          words_ok;

    // Positions past the check byte are never reached, but are handled as it.
    assign at_check = (pos_reg >= ifd_pkg::LAST_POS);
    assign pay_off  = pos_reg - ifd_pkg::POS_PAY0;
    assign pay_idx  = pay_off[ifd_pkg::PAY_IDX_W-1:0];
    assign pay_wr   = accept && !at_check && (pos_reg >= ifd_pkg::POS_PAY0);

    always_comb
    begin
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        first_next = first_reg;
        kind_next  = kind_reg;
        if (accept)
        begin
            if (at_check)
            begin
                pos_next = '0;
                sum_next = '0;
            end
            else
            begin
                pos_next = pos_reg + 4'd1;
                sum_next = sum_reg + rx_byte;
                if (pos_reg == ifd_pkg::POS_FIRST)
                begin
                    first_next = rx_byte;
                end
                if (pos_reg == ifd_pkg::POS_KIND)
                begin
                    kind_next = rx_byte;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            sum_reg   <= '0;
            first_reg <= '0;
            kind_reg  <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            first_reg <= first_next;
            kind_reg  <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pay_wr)
        begin
            pay_reg[pay_idx] <= rx_byte;
        end
    end

    // Header check outranks the sum check; equal type codes resolve in
    // rate, angle, quaternion order.
    always_comb
    begin
        if (first_reg != cfg.header_value)
        begin
            status = ifd_pkg::ST_BAD_HDR;
        end
        else if (sum_reg != rx_byte)
        begin
            status = ifd_pkg::ST_BAD_SUM;
        end
        else if (kind_reg == cfg.rate_type_code)
        begin
            status = ifd_pkg::ST_RATE;
        end
        else if (kind_reg == cfg.angle_type_code)
        begin
            status = ifd_pkg::ST_ANGLE;
        end
        else if (kind_reg == cfg.quat_type_code)
        begin
            status = ifd_pkg::ST_QUAT;
        end
        else
        begin
            status = ifd_pkg::ST_UNKNOWN;
        end
    end

    assign words_ok = (status == ifd_pkg::ST_RATE) || (status == ifd_pkg::ST_ANGLE)
                      || (status == ifd_pkg::ST_QUAT);

    always_comb
    begin
        result.frame_status = status;
        result.word_x = words_ok ? {pay_reg[1], pay_reg[0]} : '0;
        result.word_y = words_ok ? {pay_reg[3], pay_reg[2]} : '0;
        result.word_z = words_ok ? {pay_reg[5], pay_reg[4]} : '0;
        result.word_w = (status == ifd_pkg::ST_QUAT) ? {pay_reg[7], pay_reg[6]} : '0;
    end

    assign ctl.at_check = at_check;
    assign ctl.accept   = accept;

endmodule

// File: rtl/ifd_out_reg.sv
// ----------------------------------------------------------------------------
// IMU frame decoder result register
// Holds one decoded frame until the downstream side takes it.
// ----------------------------------------------------------------------------
module ifd_out_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ifd_pkg::frame_ctl_t  ctl,
    input  ifd_pkg::result_t     result,
    output logic                 full,
    ifd_result_if.source         res
);

    logic             valid_reg, valid_next;
    ifd_pkg::result_t data_reg;
    logic             load;

    assign load = ctl.accept && ctl.at_check;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    // Full means a waiting frame that is not taken in this cycle.
    assign full             = valid_reg && !res.ready;
    assign res.valid        = valid_reg;
    assign res.frame_status = data_reg.frame_status;
    assign res.word_x       = data_reg.word_x;
    assign res.word_y       = data_reg.word_y;
    assign res.word_z       = data_reg.word_z;
    assign res.word_w       = data_reg.word_w;

endmodule

// File: rtl/imu_frame_decoder.sv
// ----------------------------------------------------------------------------
// IMU frame decoder
// Splits the sensor byte stream into 11-byte windows and gives one decoded
// frame (status and four raw Q15 words) per window.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  rx       in         rx_byte
//  res      out        frame_status, word_x, word_y, word_z, word_w
//  cfg APB  in         header and type code registers, bytes 0x0..0xC
//
//  One byte is accepted per cycle while rx is ready; the frame result is registered and
//  appears the cycle after its check byte is accepted.
//  Only the check byte waits on the result register: it stalls while a
//  previous frame is still held and not being taken.
//  Reset clears position, sum, header/kind bytes, result valid; cfg gets defaults; no sweep.
// ----------------------------------------------------------------------------
module imu_frame_decoder (
    input  logic                        clk,
    input  logic                        rst_n,
    ifd_byte_if.sink                    rx,
    ifd_result_if.source                res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ifd_pkg::ADDR_W-1:0]  paddr,
    input  logic [ifd_pkg::DATA_W-1:0]  pwdata,
    output logic [ifd_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    ifd_pkg::cfg_t       cfg;
    ifd_pkg::frame_ctl_t ctl;
    ifd_pkg::result_t    result;
    logic                accept;
    logic                full;

    assign rx.ready = !ctl.at_check || !full;
    assign accept   = rx.valid && rx.ready;

    ifd_cfg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ifd_frame_unit u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx.rx_byte),
        .cfg     (cfg),
        .ctl     (ctl),
        .result  (result)
    );

    ifd_out_reg u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .result (result),
        .full   (full),
        .res    (res)
    );

`ifndef NO_ASSERTIONS
    // A new frame only shows up after a check byte transaction.
    a_rise_after_check: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res.valid) |-> $past(accept && ctl.at_check))
        else $error("result appeared without a check byte");

    // A check byte is never taken while a held frame would be overwritten.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ctl.at_check) |-> !(res.valid && !res.ready))
        else $error("held frame overwritten");

    // Frames other than quaternion carry a zero fourth word.
    a_w_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && (res.frame_status != ifd_pkg::ST_QUAT)) |-> (res.word_w == 16'sd0))
        else $error("fourth word not cleared");

    // Rejected frames carry zero words.
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && ((res.frame_status == ifd_pkg::ST_UNKNOWN)
            || (res.frame_status == ifd_pkg::ST_BAD_HDR)
            || (res.frame_status == ifd_pkg::ST_BAD_SUM)))
        |-> ((res.word_x == 16'sd0) && (res.word_y == 16'sd0) && (res.word_z == 16'sd0)))
        else $error("rejected frame carries data");
`endif

endmodule
